[hdl/cbsd_pkg.sv]
package cbsd_pkg;

  localparam int DEPTH_W = 5;

  typedef enum logic [3:0] {
    EV_UINT     = 4'd0,
    EV_NEGINT   = 4'd1,
    EV_BYTES    = 4'd2,
    EV_TEXT     = 4'd3,
    EV_ARRAY    = 4'd4,
    EV_MAP      = 4'd5,
    EV_TAG      = 4'd6,
    EV_FLOAT    = 4'd7,
    EV_NULL     = 4'd8,
    EV_PAYLOAD  = 4'd9,
    EV_KEY_HDR  = 4'd10,
    EV_KEY_BYTE = 4'd11,
    EV_ERROR    = 4'd12
  } ev_kind_t;

  typedef enum logic [3:0] {
    ERR_NONE       = 4'd0,
    ERR_TRUNCATED  = 4'd1,
    ERR_NEG_LENGTH = 4'd2,
    ERR_ARG64      = 4'd3,
    ERR_INDEF      = 4'd4,
    ERR_BAD_INFO   = 4'd5,
    ERR_KEY_TEXT   = 4'd6,
    ERR_BAD_MAJOR7 = 4'd7,
    ERR_DEPTH      = 4'd8
  } err_code_t;

  localparam logic [2:0] MAJ_UINT   = 3'd0;
  localparam logic [2:0] MAJ_NEGINT = 3'd1;
  localparam logic [2:0] MAJ_BYTES  = 3'd2;
  localparam logic [2:0] MAJ_TEXT   = 3'd3;
  localparam logic [2:0] MAJ_ARRAY  = 3'd4;
  localparam logic [2:0] MAJ_MAP    = 3'd5;
  localparam logic [2:0] MAJ_TAG    = 3'd6;
  localparam logic [2:0] MAJ_SIMPLE = 3'd7;

  localparam logic [4:0] INFO_ARG1   = 5'd24;
  localparam logic [4:0] INFO_ARG2   = 5'd25;
  localparam logic [4:0] INFO_ARG4   = 5'd26;
  localparam logic [4:0] INFO_ARG8   = 5'd27;
  localparam logic [4:0] INFO_INDEF  = 5'd31;
  localparam logic [4:0] INFO_NULL   = 5'd22;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       frame_start;
    logic       frame_end;
    logic [2:0] major;
    logic [4:0] info;
  } item_t;

  typedef struct packed {
    ev_kind_t           event_kind;
    logic [31:0]        value;
    logic [DEPTH_W-1:0] depth;
    err_code_t          error_code;
    logic               message_done;
  } event_t;

  // double to single, round to nearest even
  function automatic logic [31:0] d2s(input logic [63:0] d);
    logic [31:0] s;
    logic [10:0] e;
    logic [51:0] m;
    logic [30:0] c;
    logic [28:0] rem_n;
    logic [9:0]  sh_w;
    logic [5:0]  sh;
    logic [63:0] sig;
    logic [63:0] rem_s;
    logic [63:0] half_s;
    logic [63:0] q;
    logic [31:0] r;
    begin
      s     = {d[63], 31'd0};
      e     = d[62:52];
      m     = d[51:0];
      c     = '0;
      rem_n = m[28:0];
      sh_w  = 10'd926 - {1'b0, e[8:0]};
      sh    = sh_w[5:0];
      sig   = {11'd0, 1'b1, m};
      rem_s = '0;
      half_s = '0;
      q     = '0;
      if (e == 11'h7FF) begin
        if (m == '0) r = s | 32'h7F80_0000;
        else r = s | 32'h7FC0_0000 | {9'd0, m[51:29]};
      end else if (e == 11'd0) begin
        r = s;
      end else if (e >= 11'd1151) begin
        r = s | 32'h7F80_0000;
      end else if (e > 11'd896) begin
        c = {(e[7:0] - 8'd128), m[51:29]};
        if (rem_n > 29'h1000_0000 || (rem_n == 29'h1000_0000 && c[0])) c = c + 31'd1;
        r = s | {1'b0, c};
      end else if (e < 11'd873) begin
        r = s;
      end else begin
        q      = sig >> sh;
        rem_s  = sig & ((64'd1 << sh) - 64'd1);
        half_s = 64'd1 << (sh - 6'd1);
        if (rem_s > half_s || (rem_s == half_s && q[0])) q = q + 64'd1;
        r = s | q[31:0];
      end
      return r;
    end
  endfunction

endpackage

[hdl/cbsd_if.sv]
interface cbsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;
  logic       frame_end;
  modport source (output valid, data_byte, frame_start, frame_end, input ready);
  modport sink (input valid, data_byte, frame_start, frame_end, output ready);
endinterface

interface cbsd_ev_if;
  logic        valid;
  logic        ready;
  logic [3:0]  event_kind;
  logic [31:0] value;
  logic [4:0]  depth;
  logic [3:0]  error_code;
  logic        message_done;
  modport source (output valid, event_kind, value, depth, error_code, message_done,
                  input ready);
  modport sink (input valid, event_kind, value, depth, error_code, message_done,
                output ready);
endinterface

[hdl/cbor_stream_decoder.sv]
// Path: a byte passes the front register and the item queue, then the core writes its
// event into the event queue; output is taken from a 2-entry queue.
// Throughput: 1 byte per cycle while the event output is ready; the core's stack
// update over the per-level count registers sets that figure.
// Reset (rst, synchronous): parser at header phase, no open containers, not halted,
// all queues empty. Nesting stack entries hold no reset value.
module cbor_stream_decoder
  import cbsd_pkg::*;
#(
  parameter int MAX_DEPTH = 16
) (
  input logic         clk,
  input logic         rst,
  cbsd_in_if.sink     byte_in,
  cbsd_ev_if.source   event_out
);
  localparam int IW = $bits(item_t);
  localparam int EW = $bits(event_t);

  // front register -> item queue -> parser core -> event queue
  logic   f_valid;
  logic   f_ready;
  item_t  f_item;

  logic   q_valid;
  logic   q_ready;
  item_t  q_item;
  logic [IW-1:0] q_bits;

  logic   c_valid;
  logic   c_ready;
  event_t c_event;

  logic [EW-1:0] o_bits;
  event_t        o_event;

  cbsd_front u_front (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (byte_in.valid),
    .in_ready    (byte_in.ready),
    .data_byte   (byte_in.data_byte),
    .frame_start (byte_in.frame_start),
    .frame_end   (byte_in.frame_end),
    .out_valid   (f_valid),
    .out_ready   (f_ready),
    .out_item    (f_item)
  );

  // lets the front keep taking bytes while the core waits on the event queue
  cbsd_fifo #(.WIDTH(IW), .DEPTH(2)) u_item_q (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_bits)
  );
  assign q_item = item_t'(q_bits);

  cbsd_core #(.MAX_DEPTH(MAX_DEPTH)) u_core (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_valid),
    .in_ready  (q_ready),
    .in_item   (q_item),
    .out_valid (c_valid),
    .out_ready (c_ready),
    .out_event (c_event)
  );

  // a byte that yields no event still needs queue space to be consumed
  cbsd_fifo #(.WIDTH(EW), .DEPTH(2)) u_event_q (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (c_valid),
    .wr_ready (c_ready),
    .wr_data  (c_event),
    .rd_valid (event_out.valid),
    .rd_ready (event_out.ready),
    .rd_data  (o_bits)
  );
  assign o_event = event_t'(o_bits);

  assign event_out.event_kind   = o_event.event_kind;
  assign event_out.value        = o_event.value;
  assign event_out.depth        = o_event.depth;
  assign event_out.error_code   = o_event.error_code;
  assign event_out.message_done = o_event.message_done;
endmodule

[hdl/cbsd_fifo.sv]
module cbsd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    fill;
  logic             push;
  logic             pop;

  assign wr_ready = fill != CW'(DEPTH);
  assign rd_valid = fill != '0;
  assign rd_data  = mem[rd_ptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      if (pop) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) fill <= fill + CW'(1);
      else if (pop && !push) fill <= fill - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= wr_data;
  end
endmodule

[hdl/cbsd_front.sv]
module cbsd_front
  import cbsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       frame_start,
  input  logic       frame_end,
  output logic       out_valid,
  input  logic       out_ready,
  output item_t      out_item
);
  logic  held;
  item_t item;

  assign in_ready  = !held || out_ready;
  assign out_valid = held;
  assign out_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  // split the head byte into major type and additional info
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item.data_byte   <= data_byte;
      item.frame_start <= frame_start;
      item.frame_end   <= frame_end;
      item.major       <= data_byte[7:5];
      item.info        <= data_byte[4:0];
    end
  end
endmodule

[hdl/cbsd_core.sv]
module cbsd_core
  import cbsd_pkg::*;
#(
  parameter int MAX_DEPTH = 16
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   in_valid,
  output logic   in_ready,
  input  item_t  in_item,
  output logic   out_valid,
  input  logic   out_ready,
  output event_t out_event
);
  localparam int LW = $clog2(MAX_DEPTH + 1);
  localparam int IW = (MAX_DEPTH > 1) ? $clog2(MAX_DEPTH) : 1;

  typedef enum logic [2:0] {
    PH_HEADER, PH_ARG, PH_PAYLOAD, PH_FLOAT, PH_DONE
  } phase_t;

  phase_t      phase;
  logic [2:0]  hdr_major;
  logic [4:0]  hdr_info;
  logic [31:0] arg_val;
  logic [3:0]  arg_left;
  logic [30:0] pay_left;
  logic [63:0] fbits;
  logic [LW-1:0] level;
  logic        halted;

  logic [31:0]          cnt [MAX_DEPTH];
  logic [MAX_DEPTH-1:0] cnt_one;
  logic [MAX_DEPTH-1:0] is_map;
  logic [MAX_DEPTH-1:0] wants_key;

  phase_t      phase_e;
  logic [LW-1:0] level_e;
  logic        halted_e;
  logic [IW-1:0] top_ix;
  logic        in_key;

  logic [IW-1:0] surv;
  logic        cv_found;

  logic        take;
  logic        ev_v;
  ev_kind_t    ev_kind;
  logic [31:0] ev_val;
  err_code_t   ev_err;
  logic        ev_done;
  logic [LW-1:0] ev_depth;
  logic        do_cv;
  logic        do_ck;
  logic        do_push;
  logic        fh;
  logic [31:0] fh_a;
  phase_t      phase_next;
  logic [2:0]  maj_next;
  logic [4:0]  info_next;
  logic [31:0] arg_next;
  logic [3:0]  arg_left_next;
  logic [30:0] pay_left_next;
  logic [63:0] fbits_next;
  logic [LW-1:0] level_next;
  logic        halted_next;
  logic [3:0]  arg_dec;
  logic [30:0] pay_dec;

  assign take      = in_valid && out_ready;
  assign in_ready  = out_ready;
  assign out_valid = in_valid && ev_v;

  assign phase_e  = in_item.frame_start ? PH_HEADER : phase;
  assign level_e  = in_item.frame_start ? '0 : level;
  assign halted_e = in_item.frame_start ? 1'b0 : halted;
  assign top_ix   = IW'(level_e - LW'(1));
  assign in_key   = (level_e != '0) && is_map[top_ix] && wants_key[top_ix];
  assign arg_dec  = (arg_left != '0) ? arg_left - 4'd1 : '0;
  assign pay_dec  = (pay_left != '0) ? pay_left - 31'd1 : '0;

  // closing a value: highest open level whose count is not about to hit zero survives
  always_comb begin
    surv     = '0;
    cv_found = 1'b0;
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (LW'(i) < level_e && !cnt_one[i]) begin
        surv     = IW'(i);
        cv_found = 1'b1;
      end
    end
  end

  always_comb begin
    ev_v          = 1'b0;
    ev_kind       = EV_UINT;
    ev_val        = '0;
    ev_err        = ERR_NONE;
    do_cv         = 1'b0;
    do_ck         = 1'b0;
    do_push       = 1'b0;
    fh            = 1'b0;
    fh_a          = '0;
    phase_next    = phase_e;
    maj_next      = hdr_major;
    info_next     = hdr_info;
    arg_next      = arg_val;
    arg_left_next = arg_left;
    pay_left_next = pay_left;
    fbits_next    = fbits;
    halted_next   = halted_e;
    if (!halted_e) begin
      unique case (phase_e)
        PH_HEADER: begin
          maj_next  = in_item.major;
          info_next = in_item.info;
          arg_next  = '0;
          if (in_key && in_item.major != MAJ_TEXT) begin
            ev_v = 1'b1; ev_kind = EV_ERROR; ev_err = ERR_KEY_TEXT;
          end else if (in_item.major == MAJ_SIMPLE) begin
            if (in_item.info == INFO_ARG4 || in_item.info == INFO_ARG8) begin
              phase_next    = PH_FLOAT;
              arg_left_next = (in_item.info == INFO_ARG4) ? 4'd4 : 4'd8;
              fbits_next    = '0;
            end else if (in_item.info == INFO_NULL) begin
              ev_v = 1'b1; ev_kind = EV_NULL; do_cv = 1'b1;
            end else begin
              ev_v = 1'b1; ev_kind = EV_ERROR; ev_err = ERR_BAD_MAJOR7;
            end
          end else if (in_item.info < INFO_ARG1) begin
            arg_next = {27'd0, in_item.info};
            fh       = 1'b1;
            fh_a     = {27'd0, in_item.info};
          end else if (in_item.info == INFO_ARG1) begin
            arg_left_next = 4'd1; phase_next = PH_ARG;
          end else if (in_item.info == INFO_ARG2) begin
            arg_left_next = 4'd2; phase_next = PH_ARG;
          end else if (in_item.info == INFO_ARG4) begin
            arg_left_next = 4'd4; phase_next = PH_ARG;
          end else if (in_item.info == INFO_ARG8) begin
            ev_v = 1'b1; ev_kind = EV_ERROR; ev_err = ERR_ARG64;
          end else if (in_item.info == INFO_INDEF) begin
            ev_v = 1'b1; ev_kind = EV_ERROR; ev_err = ERR_INDEF;
          end else begin
            ev_v = 1'b1; ev_kind = EV_ERROR; ev_err = ERR_BAD_INFO;
          end
        end
        PH_ARG: begin
          arg_next      = {arg_val[23:0], in_item.data_byte};
          arg_left_next = arg_dec;
          if (arg_dec == '0) begin
            fh   = 1'b1;
            fh_a = {arg_val[23:0], in_item.data_byte};
          end
        end
        PH_FLOAT: begin
          fbits_next    = {fbits[55:0], in_item.data_byte};
          arg_left_next = arg_dec;
          if (arg_dec == '0) begin
            ev_v    = 1'b1;
            ev_kind = EV_FLOAT;
            ev_val  = (hdr_info == INFO_ARG8) ? d2s({fbits[55:0], in_item.data_byte})
                                              : {fbits[23:0], in_item.data_byte};
            do_cv   = 1'b1;
          end
        end
        PH_PAYLOAD: begin
          ev_v          = 1'b1;
          ev_kind       = in_key ? EV_KEY_BYTE : EV_PAYLOAD;
          ev_val        = {24'd0, in_item.data_byte};
          pay_left_next = pay_dec;
          if (pay_dec == '0) begin
            if (in_key) do_ck = 1'b1;
            else do_cv = 1'b1;
          end
        end
        PH_DONE: begin
        end
        default: begin
        end
      endcase

      // header argument complete
      if (fh) begin
        unique case (maj_next)
          MAJ_UINT: begin
            ev_v = 1'b1; ev_kind = EV_UINT; ev_val = fh_a; do_cv = 1'b1;
          end
          MAJ_NEGINT: begin
            ev_v = 1'b1; ev_kind = EV_NEGINT; ev_val = ~fh_a; do_cv = 1'b1;
          end
          MAJ_BYTES, MAJ_TEXT: begin
            ev_v = 1'b1;
            if (fh_a[31]) begin
              ev_kind = EV_ERROR; ev_err = ERR_NEG_LENGTH;
            end else begin
              ev_kind = in_key ? EV_KEY_HDR
                               : ((maj_next == MAJ_TEXT) ? EV_TEXT : EV_BYTES);
              ev_val  = fh_a;
              if (fh_a == '0) begin
                if (in_key) do_ck = 1'b1;
                else do_cv = 1'b1;
              end else begin
                pay_left_next = fh_a[30:0];
                phase_next    = PH_PAYLOAD;
              end
            end
          end
          MAJ_ARRAY, MAJ_MAP: begin
            ev_v = 1'b1;
            if (fh_a[31]) begin
              ev_kind = EV_ERROR; ev_err = ERR_NEG_LENGTH;
            end else if (fh_a == '0) begin
              ev_kind = (maj_next == MAJ_MAP) ? EV_MAP : EV_ARRAY;
              do_cv   = 1'b1;
            end else if (level_e >= LW'(MAX_DEPTH)) begin
              ev_kind = EV_ERROR; ev_err = ERR_DEPTH;
            end else begin
              ev_kind    = (maj_next == MAJ_MAP) ? EV_MAP : EV_ARRAY;
              ev_val     = fh_a;
              do_push    = 1'b1;
              phase_next = PH_HEADER;
            end
          end
          default: begin
            ev_v = 1'b1; ev_kind = EV_TAG; ev_val = fh_a; do_cv = 1'b1;
          end
        endcase
      end

      if (do_ck) phase_next = PH_HEADER;
      if (do_cv) phase_next = cv_found ? PH_HEADER : PH_DONE;
    end

    priority if (do_push) level_next = level_e + LW'(1);
    else if (do_cv) level_next = cv_found ? LW'(surv) + LW'(1) : '0;
    else level_next = level_e;

    ev_done  = do_cv && !cv_found;
    ev_depth = level_e;

    if (!halted_e) begin
      if (ev_v && ev_kind == EV_ERROR) begin
        halted_next = 1'b1;
      end else if (in_item.frame_end && phase_next != PH_DONE) begin
        ev_v        = 1'b1;
        ev_kind     = EV_ERROR;
        ev_err      = ERR_TRUNCATED;
        ev_val      = '0;
        ev_depth    = level_next;
        halted_next = 1'b1;
      end
    end
    if (ev_kind == EV_ERROR) ev_done = 1'b0;
  end

  assign out_event.event_kind   = ev_kind;
  assign out_event.value        = ev_val;
  assign out_event.depth        = DEPTH_W'(ev_depth);
  assign out_event.error_code   = ev_err;
  assign out_event.message_done = ev_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase  <= PH_HEADER;
      level  <= '0;
      halted <= 1'b0;
    end else if (take) begin
      phase  <= phase_next;
      level  <= level_next;
      halted <= halted_next;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      hdr_major <= maj_next;
      hdr_info  <= info_next;
      arg_val   <= arg_next;
      arg_left  <= arg_left_next;
      pay_left  <= pay_left_next;
      fbits     <= fbits_next;
    end
  end

  // one set of registers and a decrementer per nesting level
  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_DEPTH; i++) begin
      if (take && !halted_e) begin
        if (do_push && LW'(i) == level_e) begin
          cnt[i]       <= fh_a;
          cnt_one[i]   <= fh_a == 32'd1;
          is_map[i]    <= maj_next == MAJ_MAP;
          wants_key[i] <= maj_next == MAJ_MAP;
        end else if (do_cv && cv_found && IW'(i) == surv) begin
          cnt[i]     <= cnt[i] - 32'd1;
          cnt_one[i] <= cnt[i] == 32'd2;
          if (is_map[i]) wants_key[i] <= 1'b1;
        end else if (do_ck && LW'(i) + LW'(1) == level_e) begin
          wants_key[i] <= 1'b0;
        end
      end
    end
  end

  a_err_halts: assert property (@(posedge clk) disable iff (rst)
    take && ev_v && ev_kind == EV_ERROR |=> halted)
    else $error("error event did not halt the parser");

  a_push_cv_excl: assert property (@(posedge clk) disable iff (rst)
    take |-> !(do_push && do_cv))
    else $error("push and close in the same byte");

  a_done_phase: assert property (@(posedge clk) disable iff (rst)
    take && ev_v && ev_done |=> phase == PH_DONE && level == '0)
    else $error("top item completed but parser not finished");

  a_halt_silent: assert property (@(posedge clk) disable iff (rst)
    take && halted && !in_item.frame_start |-> !ev_v)
    else $error("event while halted");

  a_level_range: assert property (@(posedge clk) disable iff (rst)
    take |=> level <= LW'(MAX_DEPTH))
    else $error("nesting level beyond stack");
endmodule
